>>> rtl/isq_pkg.sv
// Shared constants for the integer square root pipeline.
`timescale 1ns / 1ps

package isq_pkg;

    // Field widths of the radicand and root ports.
    localparam int RADICAND_W = 32;
    localparam int ROOT_W     = 16;

    // Default datapath width and the number of digit steps done in one stage.
    localparam int WIDTH_DEF           = 32;
    localparam int STEPS_PER_STAGE_DEF = 2;

endpackage

>>> rtl/integer_square_root.sv
// Integer square root: a stalling pipeline of digit-by-digit root steps.
//
// The block takes one unsigned 32-bit radicand per word on the input channel
// (in_valid / in_ready / radicand) and returns floor(sqrt(radicand)) as a
// 16-bit word on the output channel (out_valid / out_ready / root).
// Radicand bits at or above WIDTH are ignored.
//
// The root is found by (WIDTH+1)/2 restoring steps, each bringing down two
// radicand bits. STEPS_PER_STAGE steps sit between two registers, so the
// pipeline has ceil(steps / STEPS_PER_STAGE) stages: 8 at the defaults.
// Each word passes through every stage register in turn; one word can enter every cycle while the receiver takes words.
//
// Each stage holds a valid bit and moves forward when the stage after it is
// empty or moving. When the receiver stalls, words pile up into empty stages
// and in_ready drops once the pipeline is full; nothing is lost or repeated.
// The last stage is the output register.
//
// Reset clears all valid bits; the pipeline is empty and ready afterward.
`timescale 1ns / 1ps

module integer_square_root #(
    parameter int WIDTH           = isq_pkg::WIDTH_DEF,
    parameter int STEPS_PER_STAGE = isq_pkg::STEPS_PER_STAGE_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic [isq_pkg::RADICAND_W-1:0] radicand,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic [isq_pkg::ROOT_W-1:0]     root
);

    import isq_pkg::*;

    localparam int STEPS  = (WIDTH + 1) / 2;
    localparam int PADW   = 2 * STEPS;
    localparam int REMW   = STEPS + 3;
    localparam int NSTAGE = (STEPS + STEPS_PER_STAGE - 1) / STEPS_PER_STAGE;

    logic [NSTAGE-1:0] valid_reg;
    logic [PADW-1:0]   rad_reg   [NSTAGE];
    logic [REMW-1:0]   rem_reg   [NSTAGE];
    logic [STEPS-1:0]  root_reg  [NSTAGE];

    logic [NSTAGE:0]   stage_ready;
    logic [PADW-1:0]   rad_pad;

    // Zero-extend or truncate the radicand to the even datapath width.
    for (genvar b = 0; b < PADW; b++) begin : g_pad
        if (b < WIDTH && b < RADICAND_W) begin : g_bit
            assign rad_pad[b] = radicand[b];
        end else begin : g_zero
            assign rad_pad[b] = 1'b0;
        end
    end

    assign stage_ready[NSTAGE] = out_ready;
    assign in_ready            = stage_ready[0];

    for (genvar s = 0; s < NSTAGE; s++) begin : g_stage
        logic              valid_next;
        logic [PADW-1:0]   rad_in;
        logic [REMW-1:0]   rem_in;
        logic [STEPS-1:0]  root_in;
        logic [PADW-1:0]   rad_next;
        logic [REMW-1:0]   rem_next;
        logic [STEPS-1:0]  root_next;

        if (s == 0) begin : g_first
            assign valid_next = in_valid;
            assign rad_in     = rad_pad;
            assign rem_in     = '0;
            assign root_in    = '0;
        end else begin : g_later
            assign valid_next = valid_reg[s-1];
            assign rad_in     = rad_reg[s-1];
            assign rem_in     = rem_reg[s-1];
            assign root_in    = root_reg[s-1];
        end

        assign stage_ready[s] = !valid_reg[s] || stage_ready[s+1];

        always_comb
        begin
            logic [REMW-1:0] trial;
            trial     = '0;
            rad_next  = rad_in;
            rem_next  = rem_in;
            root_next = root_in;
            for (int j = 0; j < STEPS_PER_STAGE; j++)
            begin
                // The last stage may hold fewer steps than the others.
                if (s * STEPS_PER_STAGE + j < STEPS)
                begin
                    rem_next  = {rem_next[REMW-3:0], rad_next[PADW-1 -: 2]};
                    trial     = {1'b0, root_next, 2'b01};
                    root_next = {root_next[STEPS-2:0], 1'b0};
                    if (rem_next >= trial)
                    begin
                        rem_next     = rem_next - trial;
                        root_next[0] = 1'b1;
                    end
                    rad_next = {rad_next[PADW-3:0], 2'b00};
                end
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                valid_reg[s] <= 1'b0;
            end
            else if (stage_ready[s])
            begin
                valid_reg[s] <= valid_next;
            end
        end

        always_ff @(posedge clk)
        begin
            if (stage_ready[s] && valid_next)
            begin
                rad_reg[s]  <= rad_next;
                rem_reg[s]  <= rem_next;
                root_reg[s] <= root_next;
            end
        end
    end

    assign out_valid = valid_reg[NSTAGE-1];

    for (genvar b = 0; b < ROOT_W; b++) begin : g_root
        if (b < STEPS) begin : g_bit
            assign root[b] = root_reg[NSTAGE-1][b];
        end else begin : g_zero
            assign root[b] = 1'b0;
        end
    end

`ifndef SYNTHESIS
    // With the receiver taking words, every stage can move.
    a_flow_through: assert property (@(posedge clk) disable iff (!rst_n)
        out_ready |-> in_ready)
        else $error("input stalled while the output is ready");

    // An accepted word lands in the first stage.
    a_enter: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> valid_reg[0])
        else $error("accepted word missing from the first stage");

    // A zero radicand keeps a zero partial root.
    a_zero_root: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready && radicand == '0) |=> (root_reg[0] == '0))
        else $error("nonzero partial root for a zero radicand");

    // With nothing entering and nothing leaving, the word count holds.
    a_count_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (!out_ready && !in_valid) |=>
            ($countones(valid_reg) == $past($countones(valid_reg))))
        else $error("word count changed while the pipeline was closed");
`endif

endmodule

>>> tb/integer_square_root_tb.sv
// Self-checking testbench for the integer square root pipeline.
`timescale 1ns / 1ps

module integer_square_root_tb;

    import isq_pkg::*;

    localparam int DIRECTED_N = 22;
    localparam int RANDOM_N   = 1700;
    localparam int QUIET_N    = 300;
    localparam int PAUSE_AT   = 600;
    localparam int DRAIN_CYC  = 20;

    class root_scoreboard;
        logic [RADICAND_W-1:0] radicand_q[$];
        logic [ROOT_W-1:0]     root_q[$];
        int                    errors;
        int                    checked;

        function new();
            errors  = 0;
            checked = 0;
        endfunction

        // Restoring digit-by-digit method: two radicand bits per step, from the top.
        function logic [ROOT_W-1:0] floor_sqrt(logic [RADICAND_W-1:0] value);
            logic [63:0] remainder;
            logic [63:0] trial;
            logic [63:0] partial;
            int          s;
            remainder = '0;
            partial   = '0;
            for (s = RADICAND_W / 2 - 1; s >= 0; s--)
            begin
                trial     = (partial << 2) | 64'd1;
                remainder = (remainder << 2) | 64'(value[2*s +: 2]);
                partial   = partial << 1;
                if (remainder >= trial)
                begin
                    remainder = remainder - trial;
                    partial   = partial | 64'd1;
                end
            end
            return partial[ROOT_W-1:0];
        endfunction

        function void note_radicand(logic [RADICAND_W-1:0] value);
            radicand_q.push_back(value);
            root_q.push_back(floor_sqrt(value));
        endfunction

        task report(string msg);
            $display("MISMATCH at %0t: %s", $realtime, msg);
            errors++;
        endtask

        task check_root(logic [ROOT_W-1:0] got);
            logic [RADICAND_W-1:0] value;
            logic [ROOT_W-1:0]     want;
            if (root_q.size() == 0)
            begin
                report($sformatf("root %0d arrived with no radicand pending", got));
            end
            else
            begin
                value = radicand_q.pop_front();
                want  = root_q.pop_front();
                checked++;
                if (got !== want)
                    report($sformatf("radicand 0x%08h: root %0d, expected %0d",
                                     value, got, want));
            end
        endtask

        function int pending();
            return root_q.size();
        endfunction
    endclass

    logic                  clk;
    logic                  rst_n;
    logic                  in_valid;
    logic                  in_ready;
    logic [RADICAND_W-1:0] radicand;
    logic                  out_valid;
    logic                  out_ready;
    logic [ROOT_W-1:0]     root;

    root_scoreboard sb;
    bit             quiet;
    int             near_squares;
    int             stall_left;

    integer_square_root uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .radicand  (radicand),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .root      (root)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // Called just after a rising edge; returns just after the edge that took the word.
    task send_word(input logic [RADICAND_W-1:0] value);
        if (!quiet && $urandom_range(0, 4) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge clk);
        end
        in_valid <= 1'b1;
        radicand <= value;
        @(negedge clk);
        while (!in_ready)
            @(negedge clk);
        @(posedge clk);
        sb.note_radicand(value);
    endtask

    function logic [RADICAND_W-1:0] pick_radicand();
        logic [RADICAND_W-1:0] k;
        case ($urandom_range(0, 5))
            0, 1: return $urandom;
            2:
            begin
                k = RADICAND_W'($urandom_range(0, 65535));
                near_squares++;
                return k * k + RADICAND_W'($urandom_range(0, 2)) - 1;
            end
            3: return $urandom >> $urandom_range(0, 31);
            4: return RADICAND_W'($urandom_range(0, 1023));
            default: return 32'hFFFE_0000 | RADICAND_W'($urandom_range(0, 32'h1FFFF));
        endcase
    endfunction

    // Receiver: out_ready changes at the rising edge, the handshake is sampled mid-cycle.
    initial
    begin
        stall_left = 0;
        forever
        begin
            @(posedge clk);
            if (stall_left > 0)
            begin
                out_ready <= 1'b0;
                stall_left--;
            end
            else
            begin
                out_ready <= 1'b1;
                if (!quiet && $urandom_range(0, 5) == 0)
                    stall_left = $urandom_range(1, 3);
            end
            @(negedge clk);
            if (rst_n && out_valid && out_ready)
                sb.check_root(root);
        end
    end

    initial
    begin
        #5ms;
        $display("Timeout with %0d roots still outstanding.", sb.pending());
        $display("DONE: errors detected");
        $finish;
    end

    initial
    begin
        logic [RADICAND_W-1:0] directed[DIRECTED_N];
        int                    i;
        sb           = new();
        quiet        = 1'b0;
        near_squares = 0;
        in_valid     = 1'b0;
        radicand     = '0;
        out_ready    = 1'b0;
        rst_n        = 1'b0;
        directed = '{32'd0, 32'd1, 32'd2, 32'd3, 32'd4, 32'd8, 32'd15, 32'd16,
                     32'd17, 32'd255, 32'd256, 32'd65535, 32'd65536,
                     32'hFFFE_0001, 32'hFFFE_0000, 32'hFFFF_FFFF, 32'h8000_0000,
                     32'h7FFF_FFFF, 32'h4000_0000, 32'h3FFF_FFFF, 32'hAAAA_AAAA,
                     32'h5555_5555};
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (i = 0; i < DIRECTED_N; i++)
            send_word(directed[i]);

        for (i = 0; i < RANDOM_N; i++)
        begin
            if (i == PAUSE_AT)
            begin
                // Let the pipeline run completely dry before carrying on.
                in_valid <= 1'b0;
                while (sb.pending() != 0)
                    @(posedge clk);
            end
            if (i == RANDOM_N - QUIET_N)
                quiet = 1'b1;
            send_word(pick_radicand());
        end
        in_valid <= 1'b0;

        while (sb.pending() != 0)
            @(posedge clk);
        repeat (DRAIN_CYC) @(posedge clk);

        $display("Checked %0d roots: %0d directed edge values, %0d random radicands",
                 sb.checked, DIRECTED_N, RANDOM_N);
        $display("(%0d of them at or next to a perfect square), with stalls on both sides.",
                 near_squares);
        if (sb.errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

>>> filelist.f
rtl/isq_pkg.sv
rtl/integer_square_root.sv
tb/integer_square_root_tb.sv
